>>> rtl/core/bcp_pkg.sv
// Package: shared types and constants for the bitstream code packer.
`timescale 1ns / 1ps

package bcp_pkg;

	localparam int ValueW  = 64;
	localparam int CountW  = 7;
	localparam int NumW    = 32;
	localparam int CapW    = 32;
	localparam int BitsW   = 35;
	localparam int LenW    = 7;
	localparam int ScanW   = 32;
	localparam int WidW    = 6;
	localparam int MaxBytes = 10;
	localparam int NbW     = 4;

	localparam logic [7:0]  LebDataMask = 8'h7F;
	localparam logic [7:0]  LebMoreBit  = 8'h80;
	localparam logic [31:0] SignedMin   = 32'h8000_0000;
	localparam logic [31:0] UegLimit    = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		FN_RAW   = 3'd0,
		FN_UEG   = 3'd1,
		FN_SEG   = 3'd2,
		FN_NSYM  = 3'd3,
		FN_LEB   = 3'd4,
		FN_FLUSH = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NOROOM = 2'd1,
		STAT_BADVAL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_NSYM_SEL,
		S_LEB_GRP,
		S_CHECK,
		S_SHIFT,
		S_SETTLE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic clr;
		logic bit_en;
		logic bit_val;
	} pk_ctrl_t;

	typedef struct packed {
		logic [BitsW-1:0] room;
		logic [NbW-1:0]   nbytes;
		logic [2:0]       offset;
		logic [7:0]       rd_byte;
	} pk_stat_t;

endpackage

>>> rtl/core/bcp_msb_scan.sv
// Serial MSB search: finds the bit width of a word, one bit per cycle.
`timescale 1ns / 1ps

module bcp_msb_scan
	import bcp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ScanW-1:0] din,
	output logic             done,
	output logic [WidW-1:0]  width
);

	logic [ScanW-1:0] sh_q;
	logic [WidW-1:0]  w_q;
	logic             busy_q;

	assign done  = busy_q && (sh_q[ScanW-1] || (w_q == '0));
	assign width = w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= din;
			w_q  <= WidW'(ScanW);
		end else if (busy_q && !done) begin
			sh_q <= {sh_q[ScanW-2:0], 1'b0};
			w_q  <= w_q - WidW'(1);
		end
	end

endmodule

>>> rtl/core/bcp_bit_packer.sv
// Bit packer: partial byte, written-bit count, room and the per-request byte buffer.
`timescale 1ns / 1ps

module bcp_bit_packer
	import bcp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  pk_ctrl_t        ctrl,
	input  logic [CapW-1:0] cap,
	input  logic [NbW-1:0]  rd_idx,
	output pk_stat_t        stat
);

	logic [6:0]       partial_q;
	logic [2:0]       offset_q;
	logic [BitsW-1:0] used_q;
	logic [BitsW-1:0] room_q;
	logic [NbW-1:0]   nbytes_q;
	logic [7:0]       buf_q [MaxBytes];
	logic [BitsW-1:0] cap_bits;
	logic [7:0]       acc;

	assign cap_bits = {cap, 3'b000};
	assign acc      = {partial_q, ctrl.bit_val};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			offset_q  <= '0;
			used_q    <= '0;
			room_q    <= '0;
			nbytes_q  <= '0;
		end else begin
			room_q <= (cap_bits >= used_q) ? (cap_bits - used_q) : '0;
			if (ctrl.clr) begin
				nbytes_q <= '0;
			end else if (ctrl.bit_en && (offset_q == 3'd7) && (nbytes_q < NbW'(MaxBytes))) begin
				nbytes_q <= nbytes_q + NbW'(1);
			end
			if (ctrl.bit_en) begin
				used_q   <= used_q + BitsW'(1);
				offset_q <= offset_q + 3'd1;
				if (offset_q == 3'd7) begin
					partial_q <= '0;
				end else begin
					partial_q <= acc[6:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.bit_en && (offset_q == 3'd7) && (nbytes_q < NbW'(MaxBytes))) begin
			buf_q[nbytes_q] <= acc;
		end
	end

	always_comb begin
		stat.room    = room_q;
		stat.nbytes  = nbytes_q;
		stat.offset  = offset_q;
		stat.rd_byte = (rd_idx < NbW'(MaxBytes)) ? buf_q[rd_idx] : '0;
	end

endmodule

>>> rtl/core/bitstream_code_packer_unit.sv
// Top level: bitstream code packer (raw, exp-Golomb, non-symmetric, LEB128, flush).
`timescale 1ns / 1ps
//
// Input channel s_axis: one request per code; tuser carries the function, tdata the
// value, raw length and alphabet size. Output channel m_axis: one result per byte
// completed by the request, or a single status-only result when none completes;
// tlast marks the final result of a request. cfg_wr_en/cfg_wr_data load the buffer
// capacity in bytes; write it only while no request is in flight.
// One request is handled at a time. After acceptance the request passes a decode step;
// for exp-Golomb and non-symmetric codes a serial MSB search of a word 1 to 32 bits
// wide, plus a select step for the non-symmetric code; a room check; the written
// bits, shifted in one per cycle (none when refused); a settle step; then one
// result per cycle while m_axis_tready is high. Each LEB128 8-bit group has a
// setup step, a room check and its shifts (none when refused). A flush shifts in
// its pad bits with no room check.
// The next request is taken the cycle after the last result is accepted.
// Reset clears the partial byte, the bit count and the capacity (zero capacity refuses
// all but flush writes). A stalled receiver holds the current result; the block waits.
//

module bitstream_code_packer_unit
	import bcp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [31:0]   cfg_wr_data,      // capacity_bytes
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [103:0]  s_axis_tdata,     // value[63:0], raw_len[70:64], alphabet_size[102:71]
	input  logic [2:0]    s_axis_tuser,     // func[2:0]
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [47:0]   m_axis_tdata,     // out_byte[7:0], status[9:8], bits_left[44:10]
	output logic          m_axis_tuser,     // byte_valid
	output logic          m_axis_tlast      // last
);

	state_t            state_q, state_d;
	logic [CapW-1:0]   cap_q;
	func_t             func_q;
	logic [ValueW-1:0] value_q;
	logic [CountW-1:0] count_q;
	logic [NumW-1:0]   nv_q;
	logic [ValueW-1:0] code_q, code_d;
	logic [LenW-1:0]   len_q, len_d;
	logic [1:0]        status_q, status_d;
	logic [ValueW-1:0] leb_q, leb_d;
	logic              more_q, more_d;
	logic [32:0]       short_q, short_d;
	logic [NbW-1:0]    rd_q, rd_d;

	pk_ctrl_t          pk_ctrl;
	pk_stat_t          pk_stat;
	logic              scan_start, scan_done;
	logic [ScanW-1:0]  scan_din;
	logic [WidW-1:0]   scan_w;

	logic              accept;
	logic [31:0]       s32, nabs;
	logic              ueg_bad, nsym_bad;
	logic [NbW-1:0]    nres;
	logic              is_last;
	logic [5:0]        bit_idx;
	logic [LenW-1:0]   len_m1;

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign s32     = value_q[31:0];
	assign nabs    = ~s32 + 32'd1;
	assign ueg_bad = (value_q[63:32] != '0) || (value_q[31:0] == UegLimit);
	assign nsym_bad = (nv_q == '0) || (nv_q > SignedMin) || (value_q >= {32'd0, nv_q});
	assign nres    = (pk_stat.nbytes != '0) ? pk_stat.nbytes : NbW'(1);
	assign is_last = (rd_q == nres - NbW'(1));
	assign len_m1  = len_q - LenW'(1);
	assign bit_idx = len_m1[5:0];

	bcp_msb_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.din    (scan_din),
		.done   (scan_done),
		.width  (scan_w)
	);

	bcp_bit_packer u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (pk_ctrl),
		.cap    (cap_q),
		.rd_idx (rd_q),
		.stat   (pk_stat)
	);

	always_comb begin
		state_d    = state_q;
		code_d     = code_q;
		len_d      = len_q;
		status_d   = status_q;
		leb_d      = leb_q;
		more_d     = more_q;
		short_d    = short_q;
		rd_d       = rd_q;
		scan_start = 1'b0;
		scan_din   = value_q[31:0];
		pk_ctrl    = '0;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (accept) begin
					pk_ctrl.clr = 1'b1;
					status_d    = STAT_OK;
					more_d      = 1'b0;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				code_d = value_q;
				case (func_q)
					FN_RAW: begin
						len_d = count_q;
						if (count_q > CountW'(ValueW)) begin
							status_d = STAT_BADVAL;
							state_d  = S_SETTLE;
						end else if (count_q == '0) begin
							state_d = S_SETTLE;
						end else begin
							state_d = S_CHECK;
						end
					end
					FN_UEG: begin
						if (ueg_bad) begin
							status_d = STAT_BADVAL;
							state_d  = S_SETTLE;
						end else begin
							scan_din   = value_q[31:0] + 32'd1;
							code_d     = {32'd0, scan_din};
							scan_start = 1'b1;
							state_d    = S_SCAN;
						end
					end
					FN_SEG: begin
						if (s32 == SignedMin) begin
							status_d = STAT_BADVAL;
							state_d  = S_SETTLE;
						end else begin
							if (s32[31]) begin
								scan_din = {nabs[30:0], 1'b1};
							end else if (s32 == '0) begin
								scan_din = 32'd1;
							end else begin
								scan_din = {s32[30:0], 1'b0};
							end
							code_d     = {32'd0, scan_din};
							scan_start = 1'b1;
							state_d    = S_SCAN;
						end
					end
					FN_NSYM: begin
						if (nsym_bad) begin
							status_d = STAT_BADVAL;
							state_d  = S_SETTLE;
						end else if (nv_q == 32'd1) begin
							state_d = S_SETTLE;
						end else begin
							scan_din   = nv_q;
							scan_start = 1'b1;
							state_d    = S_SCAN;
						end
					end
					FN_LEB: begin
						leb_d   = value_q;
						state_d = S_LEB_GRP;
					end
					FN_FLUSH: begin
						code_d = '0;
						len_d  = LenW'(8) - LenW'(pk_stat.offset);
						if (pk_stat.offset != '0) begin
							state_d = S_SHIFT;
						end else begin
							state_d = S_SETTLE;
						end
					end
					default: begin
						status_d = STAT_BADVAL;
						state_d  = S_SETTLE;
					end
				endcase
			end
			S_SCAN: begin
				if (scan_done) begin
					if (func_q == FN_NSYM) begin
						short_d = (33'd1 << scan_w) - {1'b0, nv_q};
						state_d = S_NSYM_SEL;
					end else begin
						len_d   = {scan_w, 1'b0} - LenW'(1);
						state_d = S_CHECK;
					end
				end
			end
			S_NSYM_SEL: begin
				if (value_q[32:0] < short_q) begin
					code_d = value_q;
					len_d  = LenW'(scan_w) - LenW'(1);
				end else begin
					code_d = {31'd0, value_q[32:0] + short_q};
					len_d  = LenW'(scan_w);
				end
				state_d = S_CHECK;
			end
			S_LEB_GRP: begin
				more_d  = (leb_q[63:7] != '0);
				code_d  = {56'd0, (leb_q[7:0] & LebDataMask) | (more_d ? LebMoreBit : 8'h00)};
				len_d   = LenW'(8);
				leb_d   = {7'd0, leb_q[63:7]};
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (BitsW'(len_q) > pk_stat.room) begin
					status_d = STAT_NOROOM;
					state_d  = (func_q == FN_LEB && more_q) ? S_LEB_GRP : S_SETTLE;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				pk_ctrl.bit_en  = 1'b1;
				pk_ctrl.bit_val = code_q[bit_idx];
				len_d           = len_m1;
				if (len_q == LenW'(1)) begin
					state_d = (func_q == FN_LEB && more_q) ? S_LEB_GRP : S_SETTLE;
				end
			end
			S_SETTLE: begin
				rd_d    = '0;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					if (is_last) begin
						state_d = S_IDLE;
					end else begin
						rd_d = rd_q + NbW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q   <= '0;
			more_q  <= 1'b0;
			rd_q    <= '0;
		end else begin
			state_q <= state_d;
			more_q  <= more_d;
			rd_q    <= rd_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func_t'(s_axis_tuser);
			value_q <= s_axis_tdata[63:0];
			count_q <= s_axis_tdata[70:64];
			nv_q    <= s_axis_tdata[102:71];
		end
		code_q   <= code_d;
		len_q    <= len_d;
		status_q <= status_d;
		leb_q    <= leb_d;
		short_q  <= short_d;
	end

	assign m_axis_tdata = {3'd0, pk_stat.room, status_q,
		(pk_stat.nbytes != '0) ? pk_stat.rd_byte : 8'h00};
	assign m_axis_tuser = (pk_stat.nbytes != '0);
	assign m_axis_tlast = is_last;

endmodule

>>> tb/sv/tb_top.sv
// Testbench for the bitstream code packer: directed table plus random codes, checked per result.
`timescale 1ns / 1ps

module tb_top;
	import bcp_pkg::*;

	localparam logic [2:0] FN_UNDEF_LO = 3'd6;
	localparam logic [2:0] FN_UNDEF_HI = 3'd7;
	localparam int unsigned PHASES = 6;
	localparam int unsigned PHASE_ITEMS = 50;
	localparam int unsigned TAIL_CYCLES = 200;

	typedef enum {CAP_KEEP, CAP_MAX, CAP_TIGHT, CAP_ONE} cap_step_t;

	typedef struct {
		cap_step_t   cap_step;
		logic [2:0]  fn;
		logic [63:0] value;
		logic [6:0]  count;
		logic [31:0] nv;
		bit          typed;
		status_t     st;
		logic [34:0] left;
	} code_req_t;

	typedef struct {
		logic [7:0]  data;
		logic        has_byte;
		status_t     st;
		logic        last;
		logic [34:0] left;
	} byte_result_t;

	logic          clk;
	logic          arst_n;
	logic          cfg_wr_en;
	logic [31:0]   cfg_wr_data;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [103:0]  s_axis_tdata;     // value[63:0], raw_len[70:64], alphabet_size[102:71]
	logic [2:0]    s_axis_tuser;     // func[2:0]
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [47:0]   m_axis_tdata;     // out_byte[7:0], status[9:8], bits_left[44:10]
	logic          m_axis_tuser;     // byte_valid
	logic          m_axis_tlast;     // last

	// packer state mirror
	logic [31:0]   cap_bytes;
	logic [6:0]    pk_partial;
	logic [2:0]    pk_offset;
	logic [63:0]   pk_used;
	logic [7:0]    bytes_made[$];

	byte_result_t  owed_results[$];
	code_req_t     dir_rows[$];
	bit            idle_on;
	int unsigned   errors;
	int unsigned   req_count;
	int unsigned   beat_count;
	int unsigned   cap_loads;

	bitstream_code_packer_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [63:0] room_bits();
		logic [63:0] c;
		c = {29'd0, cap_bytes, 3'd0};
		return (pk_used >= c) ? 64'd0 : c - pk_used;
	endfunction

	function automatic void put_bit(logic b);
		logic [7:0] acc;
		acc = {pk_partial, b};
		pk_used = pk_used + 64'd1;
		if (pk_offset == 3'd7) begin
			bytes_made.push_back(acc);
			pk_partial = '0;
			pk_offset = '0;
		end else begin
			pk_partial = acc[6:0];
			pk_offset = pk_offset + 3'd1;
		end
	endfunction

	function automatic int unsigned msb_width(logic [63:0] v);
		for (int i = 63; i >= 0; i--)
			if (v[i]) return i + 1;
		return 0;
	endfunction

	// all n bits or none
	function automatic status_t write_whole(logic [63:0] v, int unsigned n);
		if (64'(n) > room_bits()) return STAT_NOROOM;
		for (int i = n; i > 0; i--)
			put_bit(v[i-1]);
		return STAT_OK;
	endfunction

	function automatic status_t write_ueg(logic [63:0] code);
		logic [63:0] v1;
		if (code >= {32'd0, UegLimit}) return STAT_BADVAL;
		v1 = code + 64'd1;
		return write_whole(v1, msb_width(v1) * 2 - 1);
	endfunction

	function automatic void pack_request(code_req_t r);
		status_t      st;
		logic [31:0]  s;
		logic [63:0]  v;
		logic [63:0]  short_cnt;
		logic [7:0]   b;
		int unsigned  w;
		logic [34:0]  left;
		byte_result_t res;
		st = STAT_OK;
		bytes_made.delete();
		case (r.fn)
			FN_RAW: begin
				if (r.count > 7'd64) st = STAT_BADVAL;
				else if (r.count != 7'd0) st = write_whole(r.value, r.count);
			end
			FN_UEG: st = write_ueg(r.value);
			FN_SEG: begin
				s = r.value[31:0];
				if (s == SignedMin) st = STAT_BADVAL;
				else if (s[31]) st = write_ueg({31'd0, (~s) + 32'd1, 1'b0});
				else if (s == 32'd0) st = write_ueg(64'd0);
				else st = write_ueg({31'd0, s, 1'b0} - 64'd1);
			end
			FN_NSYM: begin
				if (r.nv == 32'd0 || r.nv > SignedMin || r.value >= {32'd0, r.nv}) begin
					st = STAT_BADVAL;
				end else if (r.nv > 32'd1) begin
					w = msb_width({32'd0, r.nv});
					short_cnt = (64'd1 << w) - {32'd0, r.nv};
					if (r.value < short_cnt) st = write_whole(r.value, w - 1);
					else st = write_whole(r.value + short_cnt, w);
				end
			end
			FN_LEB: begin
				v = r.value;
				do begin
					b = v[7:0] & LebDataMask;
					v = v >> 7;
					if (v != 64'd0) b = b | LebMoreBit;
					if (write_whole({56'd0, b}, 8) != STAT_OK) st = STAT_NOROOM;
				end while (v != 64'd0);
			end
			FN_FLUSH: begin
				while (pk_offset != 3'd0)
					put_bit(1'b0);
			end
			default: st = STAT_BADVAL;
		endcase
		left = 35'(room_bits());
		if (r.typed) begin
			res = '{data: 8'd0, has_byte: 1'b0, st: r.st, last: 1'b1, left: r.left};
			owed_results.push_back(res);
		end else if (bytes_made.size() == 0) begin
			res = '{data: 8'd0, has_byte: 1'b0, st: st, last: 1'b1, left: left};
			owed_results.push_back(res);
		end else begin
			foreach (bytes_made[k]) begin
				res = '{data: bytes_made[k], has_byte: 1'b1, st: st,
					last: (k == bytes_made.size() - 1), left: left};
				owed_results.push_back(res);
			end
		end
	endfunction

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
		errors++;
	endtask

	task automatic add_row(cap_step_t cs, logic [2:0] fn, logic [63:0] value,
			logic [6:0] count, logic [31:0] nv, bit typed, status_t st);
		code_req_t r;
		r = '{cap_step: cs, fn: fn, value: value, count: count, nv: nv,
			typed: typed, st: st, left: 35'd0};
		dir_rows.push_back(r);
	endtask

	task automatic send_request(code_req_t r);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, r.nv, r.count, r.value};
		s_axis_tuser <= r.fn;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pack_request(r);
		req_count++;
	endtask

	// wait for the block to go quiet, then load a new capacity
	task automatic reload_capacity(logic [31:0] c);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cap_bytes = c;
		cap_loads++;
	endtask

	// result side: random stalls, check each accepted beat
	initial begin
		int unsigned  stall;
		byte_result_t want;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_on ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			beat_count++;
			if (owed_results.size() == 0) begin
				flag_mismatch("unexpected result", 64'(m_axis_tdata), 64'd0);
			end else begin
				want = owed_results.pop_front();
				if (m_axis_tdata[7:0] !== want.data)
					flag_mismatch("out_byte", 64'(m_axis_tdata[7:0]), 64'(want.data));
				if (m_axis_tuser !== want.has_byte)
					flag_mismatch("byte_valid", 64'(m_axis_tuser), 64'(want.has_byte));
				if (m_axis_tdata[9:8] !== want.st)
					flag_mismatch("status", 64'(m_axis_tdata[9:8]), 64'(want.st));
				if (m_axis_tlast !== want.last)
					flag_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
				if (m_axis_tdata[44:10] !== want.left)
					flag_mismatch("bits_left", 64'(m_axis_tdata[44:10]), 64'(want.left));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Timeout waiting for the packer");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		code_req_t    r;
		logic [31:0]  c;
		logic [31:0]  used_bytes;
		logic [31:0]  mag;
		int unsigned  sel;
		int unsigned  dir_count;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cap_bytes = '0;
		pk_partial = '0;
		pk_offset = '0;
		pk_used = '0;
		idle_on = 1'b1;
		errors = 0;
		req_count = 0;
		beat_count = 0;
		cap_loads = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// zero capacity after reset: every write refused
		add_row(CAP_KEEP, FN_RAW,      64'hA5,                  7'd8,   32'd1, 1, STAT_NOROOM);
		add_row(CAP_KEEP, FN_RAW,      64'hFFFF,                7'd0,   32'd1, 1, STAT_OK);
		add_row(CAP_KEEP, FN_RAW,      64'h1,                   7'd65,  32'd1, 1, STAT_BADVAL);
		add_row(CAP_KEEP, FN_UEG,      64'hFFFF_FFFF,           7'd0,   32'd1, 1, STAT_BADVAL);
		add_row(CAP_KEEP, FN_SEG,      64'h8000_0000,           7'd0,   32'd1, 1, STAT_BADVAL);
		add_row(CAP_KEEP, FN_NSYM,     64'h0,                   7'd0,   32'd0, 1, STAT_BADVAL);
		add_row(CAP_KEEP, FN_NSYM,     64'h0,                   7'd0,
			32'h8000_0001, 1, STAT_BADVAL);
		add_row(CAP_KEEP, FN_UNDEF_LO, 64'h0,                   7'd8,   32'd1, 1, STAT_BADVAL);
		add_row(CAP_KEEP, FN_UNDEF_HI, 64'hFFFF_FFFF_FFFF_FFFF, 7'h7F,
			32'hFFFF_FFFF, 1, STAT_BADVAL);
		add_row(CAP_KEEP, FN_FLUSH,    64'h0,                   7'd0,   32'd1, 1, STAT_OK);
		add_row(CAP_KEEP, FN_LEB,      64'h0,                   7'd0,   32'd1, 1, STAT_NOROOM);
		add_row(CAP_KEEP, FN_NSYM,     64'h0,                   7'd0,   32'd1, 1, STAT_OK);
		// full capacity
		add_row(CAP_MAX,  FN_RAW,      64'hFFFF_FFFF_FFFF_FFFF, 7'd64,  32'd1, 0, STAT_OK);
		add_row(CAP_KEEP, FN_RAW,      64'h1,                   7'd1,   32'd1, 0, STAT_OK);
		add_row(CAP_KEEP, FN_UEG,      64'h0,                   7'd0,   32'd1, 0, STAT_OK);
		add_row(CAP_KEEP, FN_UEG,      64'hFFFF_FFFE,           7'd0,   32'd1, 0, STAT_OK);
		add_row(CAP_KEEP, FN_SEG,      64'h1,                   7'd0,   32'd1, 0, STAT_OK);
		add_row(CAP_KEEP, FN_SEG,      64'hFFFF_FFFF,           7'd0,   32'd1, 0, STAT_OK);
		add_row(CAP_KEEP, FN_SEG,      64'hFFFF_FFFF_7FFF_FFFF, 7'd0,   32'd1, 0, STAT_OK);
		add_row(CAP_KEEP, FN_NSYM,     64'h7FFF_FFFF,           7'd0,
			32'h8000_0000, 0, STAT_OK);
		add_row(CAP_KEEP, FN_NSYM,     64'h4,                   7'd0,   32'd5, 0, STAT_OK);
		add_row(CAP_KEEP, FN_LEB,      64'hFFFF_FFFF_FFFF_FFFF, 7'd0,   32'd1, 0, STAT_OK);
		add_row(CAP_KEEP, FN_FLUSH,    64'h0,                   7'd0,   32'd1, 0, STAT_OK);
		add_row(CAP_KEEP, FN_RAW,      64'h5,                   7'd3,   32'd1, 0, STAT_OK);
		// room for one more group only: LEB128 partly written
		add_row(CAP_TIGHT, FN_LEB,     64'hFFFF_FFFF_FFFF_FFFF, 7'd0,   32'd1, 0, STAT_OK);
		add_row(CAP_KEEP, FN_RAW,      64'h6,                   7'd3,   32'd1, 0, STAT_OK);
		// capacity below use: writes refused, flush still pads
		add_row(CAP_ONE,  FN_RAW,      64'h3,                   7'd2,   32'd1, 1, STAT_NOROOM);
		add_row(CAP_KEEP, FN_FLUSH,    64'h0,                   7'd0,   32'd1, 0, STAT_OK);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].cap_step)
				CAP_MAX:   reload_capacity(32'hFFFF_FFFF);
				CAP_TIGHT: reload_capacity(32'((pk_used + 64'd7) >> 3) + 32'd1);
				CAP_ONE:   reload_capacity(32'd1);
				default: ;
			endcase
			send_request(dir_rows[i]);
		end
		dir_count = req_count;

		for (int p = 0; p < PHASES; p++) begin
			used_bytes = 32'(pk_used >> 3);
			case (p)
				0: c = 32'hFFFF_FFFF;
				1: c = used_bytes + $urandom_range(4, 24);
				2: c = $urandom;
				3: c = used_bytes + $urandom_range(1, 8);
				4: c = 32'd0;
				default: c = $urandom_range(0, used_bytes);
			endcase
			reload_capacity(c);
			idle_on = (p != 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				sel = $urandom_range(0, 99);
				r.cap_step = CAP_KEEP;
				r.typed = 0;
				r.st = STAT_OK;
				r.left = '0;
				r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
				r.count = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(0, 127))
					: 7'($urandom_range(0, 64));
				r.nv = $urandom >> $urandom_range(0, 31);
				if (sel < 30) begin
					r.fn = FN_RAW;
				end else if (sel < 45) begin
					r.fn = FN_UEG;
					if ($urandom_range(0, 3) != 0)
						r.value = {$urandom, $urandom} >> $urandom_range(24, 63);
				end else if (sel < 60) begin
					r.fn = FN_SEG;
					mag = $urandom >> $urandom_range(0, 31);
					r.value = {$urandom, ($urandom_range(0, 1) != 0) ? -mag : mag};
				end else if (sel < 75) begin
					r.fn = FN_NSYM;
					if ($urandom_range(0, 7) != 0) begin
						if (r.nv == 32'd0 || r.nv > SignedMin) r.nv = $urandom >> 1;
						if (r.nv == 32'd0) r.nv = 32'd1;
						r.value = {32'd0, $urandom} % {32'd0, r.nv};
					end
				end else if (sel < 85) begin
					r.fn = FN_LEB;
				end else if (sel < 95) begin
					r.fn = FN_FLUSH;
				end else begin
					r.fn = ($urandom_range(0, 1) != 0) ? FN_UNDEF_HI : FN_UNDEF_LO;
				end
				send_request(r);
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d code requests (%0d from the directed table) over %0d capacity loads,",
			req_count, dir_count, cap_loads);
		$display("checked %0d output beats, %0d mismatches", beat_count, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/bcp_pkg.sv
rtl/core/bcp_msb_scan.sv
rtl/core/bcp_bit_packer.sv
rtl/core/bitstream_code_packer_unit.sv
tb/sv/tb_top.sv
